// ----- hw/rtl/line_edit_buffer_utf8_backspace_assert.svh -----
// Assertion macros shared by the line edit buffer modules.
`ifndef LINE_EDIT_BUFFER_UTF8_BACKSPACE_ASSERT_SVH
`define LINE_EDIT_BUFFER_UTF8_BACKSPACE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LEBU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LEBU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/lebu_pkg.sv -----
// Shared constants, command codes and types of the line edit buffer.
package lebu_pkg;

  // Size of the line store and the widths that follow from it.
  localparam int LINE_BYTES = 32;
  localparam int CNTW = $clog2(LINE_BYTES + 1);
  localparam int IDXW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;

  // Command queue between front and back; the depth is a power of two.
  localparam int QDEPTH = 2;
  localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  // Input item kinds.
  localparam logic [1:0] KIND_EDIT  = 2'd0;
  localparam logic [1:0] KIND_RAW   = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  // Special byte values.
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] UTF8_CONT_MASK = 8'hC0;
  localparam logic [7:0] UTF8_CONT_TAG  = 8'h80;

  // Commands that the front hands to the back.
  localparam int OPW = 3;
  localparam logic [OPW-1:0] OP_STORE   = 3'd0;
  localparam logic [OPW-1:0] OP_BACK    = 3'd1;
  localparam logic [OPW-1:0] OP_NEWLINE = 3'd2;
  localparam logic [OPW-1:0] OP_RAW     = 3'd3;
  localparam logic [OPW-1:0] OP_FLUSH   = 3'd4;

  typedef struct packed {
    logic [OPW-1:0] op;
    logic [7:0]     data;
  } cmd_t;

endpackage

// ----- hw/rtl/line_edit_buffer_utf8_backspace.sv -----
// A raw byte passes from the command queue through ST_RAW to the registered result port.
// A drain reads each held byte in ST_DRD and sends it from ST_DOUT; a newline adds ST_NL for its own byte.
// A backspace reads each byte stepped back in ST_BRD and checks it in ST_BCHK; a stored byte is written in ST_WR.
// The back end takes one command at a time on its single-port line store, one access per cycle.
// Reset clears the fill count, command queue and output valid; store contents stay.
module line_edit_buffer_utf8_backspace import lebu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] kind,
  input  logic [7:0] data_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic       last
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Item classification and command queue.
  lebu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .kind       (kind),
    .data_byte  (data_byte),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  // Line store and result sequencing.
  lebu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .last         (last)
  );

endmodule

// ----- hw/rtl/lebu_front.sv -----
// Front end: accepts items, classifies them and queues commands for the back end.
`include "line_edit_buffer_utf8_backspace_assert.svh"
module lebu_front import lebu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] kind,
  input  logic [7:0] data_byte,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_pop
);

  cmd_t           q [QDEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           keep;
  logic           push;
  cmd_t           new_cmd;

  // Classify the item; dropped bytes and the unused kind make no command.
  always_comb begin
    keep = 1'b1;
    new_cmd.op = OP_STORE;
    new_cmd.data = data_byte;
    case (kind)
      KIND_RAW: begin
        new_cmd.op = OP_RAW;
      end
      KIND_FLUSH: begin
        new_cmd.op = OP_FLUSH;
      end
      KIND_EDIT: begin
        if (data_byte == CH_NUL || data_byte == CH_BEL) begin
          keep = 1'b0;
        end else if (data_byte == CH_BS) begin
          new_cmd.op = OP_BACK;
        end else if (data_byte == CH_LF) begin
          new_cmd.op = OP_NEWLINE;
        end else begin
          new_cmd.op = OP_STORE;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign item_stall = (count == QCW'(QDEPTH));
  assign push = item_valid && !item_stall && keep;
  assign cmd_valid = (count != '0);
  assign cmd = q[rd_ptr];

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPW'(1);
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + QPW'(1);
      end
      count <= count + QCW'(push) - QCW'(cmd_pop);
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= new_cmd;
    end
  end

  `LEBU_ASSERT_NOW(a_count_range, 1'b1, count <= QCW'(QDEPTH), "queue count out of range")
  `LEBU_ASSERT_NOW(a_pop_nonempty, cmd_pop, count != '0, "pop from an empty queue")

endmodule

// ----- hw/rtl/lebu_back.sv -----
// Back end: executes queued commands on the line store and drives the results.
`include "line_edit_buffer_utf8_backspace_assert.svh"
module lebu_back import lebu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic       last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DRD  = 3'd1;
  localparam logic [2:0] ST_DOUT = 3'd2;
  localparam logic [2:0] ST_NL   = 3'd3;
  localparam logic [2:0] ST_RAW  = 3'd4;
  localparam logic [2:0] ST_WR   = 3'd5;
  localparam logic [2:0] ST_BRD  = 3'd6;
  localparam logic [2:0] ST_BCHK = 3'd7;

  logic [7:0]      mem [LINE_BYTES];
  logic [7:0]      rd_data;
  logic [2:0]      state, state_next;
  logic [CNTW-1:0] fill, fill_next;
  logic [IDXW-1:0] idx, idx_next;
  logic [OPW-1:0]  op;
  logic [7:0]      data;
  logic            mem_we, mem_re;
  logic [IDXW-1:0] mem_addr;
  logic            out_free, out_load;
  logic [7:0]      out_byte_next;
  logic            last_next;
  logic            drain_end;

  assign out_free = !result_valid || !result_stall;
  assign cmd_pop = cmd_valid && (state == ST_IDLE);
  assign drain_end = (CNTW'(idx) == fill - CNTW'(1));

  // Command sequencer.
  always_comb begin
    state_next = state;
    fill_next = fill;
    idx_next = idx;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_addr = idx;
    out_load = 1'b0;
    out_byte_next = rd_data;
    last_next = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          idx_next = '0;
          case (cmd.op)
            OP_RAW: begin
              state_next = ST_RAW;
            end
            OP_FLUSH: begin
              state_next = (fill == '0) ? ST_IDLE : ST_DRD;
            end
            OP_NEWLINE: begin
              state_next = (fill == '0) ? ST_NL : ST_DRD;
            end
            OP_STORE: begin
              state_next = (fill == CNTW'(LINE_BYTES)) ? ST_DRD : ST_WR;
            end
            OP_BACK: begin
              idx_next = IDXW'(fill - CNTW'(1));
              state_next = (fill == '0) ? ST_IDLE : ST_BRD;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_DRD: begin
        mem_re = 1'b1;
        state_next = ST_DOUT;
      end
      ST_DOUT: begin
        if (out_free) begin
          out_load = 1'b1;
          last_next = drain_end && (op != OP_NEWLINE);
          if (drain_end) begin
            fill_next = '0;
            if (op == OP_NEWLINE) begin
              state_next = ST_NL;
            end else if (op == OP_STORE) begin
              state_next = ST_WR;
            end else begin
              state_next = ST_IDLE;
            end
          end else begin
            idx_next = idx + IDXW'(1);
            state_next = ST_DRD;
          end
        end
      end
      ST_NL: begin
        if (out_free) begin
          out_load = 1'b1;
          out_byte_next = CH_LF;
          last_next = 1'b1;
          fill_next = '0;
          state_next = ST_IDLE;
        end
      end
      ST_RAW: begin
        if (out_free) begin
          out_load = 1'b1;
          out_byte_next = data;
          last_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_WR: begin
        mem_we = 1'b1;
        mem_addr = IDXW'(fill);
        fill_next = fill + CNTW'(1);
        state_next = ST_IDLE;
      end
      ST_BRD: begin
        // Position zero ends the step back without a look at its byte.
        if (idx == '0) begin
          fill_next = '0;
          state_next = ST_IDLE;
        end else begin
          mem_re = 1'b1;
          state_next = ST_BCHK;
        end
      end
      ST_BCHK: begin
        // A continuation byte belongs to the character being removed.
        if ((rd_data & UTF8_CONT_MASK) == UTF8_CONT_TAG) begin
          idx_next = idx - IDXW'(1);
          state_next = ST_BRD;
        end else begin
          fill_next = CNTW'(idx);
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill <= fill_next;
      result_valid <= out_load || (result_valid && result_stall);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (cmd_pop) begin
      op <= cmd.op;
      data <= cmd.data;
    end
    if (out_load) begin
      out_byte <= out_byte_next;
      last <= last_next;
    end
  end

  // Line store with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= data;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  `LEBU_ASSERT_NOW(a_fill_range, 1'b1, fill <= CNTW'(LINE_BYTES), "fill count out of range")
  `LEBU_ASSERT_NOW(a_write_room, mem_we, fill < CNTW'(LINE_BYTES), "store write into a full line")
  `LEBU_ASSERT_NOW(a_drain_addr, state == ST_DRD, CNTW'(idx) < fill, "drain read beyond the line")
  `LEBU_ASSERT_NEXT(a_nl_last, state == ST_NL && out_free, result_valid && last,
    "newline result not marked last")

endmodule
